// ===== src/ogc_pkg.sv =====
// Shared constants, types and the sine table function for the occupancy grid hit counter.
package ogc_pkg;

  // Grid geometry and counter size
  localparam int GRID_DIM   = 64;
  localparam int TILE_MM    = 128;   // must be a power of two
  localparam int COUNT_BITS = 16;

  localparam int GRID_BITS  = $clog2(GRID_DIM);
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM;
  localparam int GRID_AW    = 2 * GRID_BITS;

  // Port field widths
  localparam int DIST_W    = 14;
  localparam int ANG_W     = 13;
  localparam int POS_W     = 16;
  localparam int CELL_W    = 6;
  localparam int CNT_OUT_W = 16;
  localparam int THR_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OCC_THR   = 1'b1;
  localparam logic [THR_W-1:0]     THR_RESET     = 16'd5;

  // Opcodes
  localparam logic OP_RETURN = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Angles in 1/16 degree
  localparam int FULL_TURN    = 5760;
  localparam int QUARTER_TURN = 1440;
  localparam int SIN_DEPTH    = QUARTER_TURN + 1;
  localparam int SIN_AW       = $clog2(SIN_DEPTH);
  localparam int SIN_W        = 15;   // magnitude, Q15
  localparam int TRIG_W       = 16;   // signed sine / cosine
  localparam int PROD_W       = DIST_W + 1 + TRIG_W;

  // Projection in Q15 millimeters; x uses a divisor of 4 tiles, y of 2 tiles
  localparam int    Q15_SH  = 15;
  localparam int    NW      = 40;
  localparam longint TILE_Q = longint'(TILE_MM) << Q15_SH;
  localparam longint GRID_Q = longint'(GRID_DIM) * TILE_Q;
  localparam longint DIV_X  = 4 * TILE_Q;
  localparam longint DIV_Y  = 2 * TILE_Q;
  localparam int     X_SH   = $clog2(DIV_X);
  localparam int     Y_SH   = $clog2(DIV_Y);
  localparam logic signed [NW-1:0] GRID_Q_N = NW'(GRID_Q);
  localparam logic signed [NW-1:0] X_LO     = NW'(-DIV_X);
  localparam logic signed [NW-1:0] X_HI     = NW'(longint'(GRID_DIM) * DIV_X);
  localparam logic signed [NW-1:0] Y_LO     = NW'(-DIV_Y);
  localparam logic signed [NW-1:0] Y_HI     = NW'(longint'(GRID_DIM) * DIV_Y);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Reset sweep: clears the grid and loads the sine tables
  localparam int CLR_LEN = (GRID_CELLS > SIN_DEPTH) ? GRID_CELLS : SIN_DEPTH;
  localparam int CLR_W   = $clog2(CLR_LEN);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ogc_state_e;

  typedef struct packed {
    logic             grid_we;
    logic             sine_we;
    logic [CLR_W-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic                    op;
    logic                    ok;     // return passes parity, motion and range checks
    logic [DIST_W-1:0]       range_mm;
    logic signed [POS_W-1:0] rx;
    logic signed [POS_W-1:0] ry;
    logic [CELL_W-1:0]       rrow;
    logic [CELL_W-1:0]       rcol;
  } item_t;

  typedef struct packed {
    logic               vld;
    logic               wr;    // increment this cell
    logic               rd;    // report this cell
    logic [GRID_AW-1:0] addr;
    logic [CELL_W-1:0]  col;
    logic [CELL_W-1:0]  row;
  } cell_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]    col;
    logic [CELL_W-1:0]    row;
    logic                 counted;
    logic [CNT_OUT_W-1:0] count;
    logic                 occupied;
  } result_t;

  // Quarter-wave sine in Q15: Taylor series to z^7 in Q30, rounded and capped.
  localparam logic [63:0] COEF_A = 64'd1686629713;
  localparam logic [63:0] COEF_B = 64'd693598668;
  localparam logic [63:0] COEF_C = 64'd85569288;
  localparam logic [63:0] COEF_D = 64'd5026990;

  function automatic logic [SIN_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] v;
    logic [63:0] q;
    z  = (64'(r) << 30) / 64'(QUARTER_TURN);
    z2 = (z * z) >> 30;
    v  = COEF_C - ((z2 * COEF_D) >> 30);
    v  = COEF_B - ((z2 * v) >> 30);
    v  = COEF_A - ((z2 * v) >> 30);
    v  = (z * v) >> 30;
    q  = (v + 64'd16384) >> 15;
    return (q > 64'd32767) ? 15'h7FFF : q[SIN_W-1:0];
  endfunction

endpackage

// ===== src/ogc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ogc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ogc_trig.sv =====
// Angle reduction and sine/cosine lookup from quarter-wave table RAMs.
module ogc_trig (
  input  logic                            clk_i,
  input  logic                            adv_i,
  input  logic [ogc_pkg::ANG_W-1:0]       heading_i,
  input  logic [ogc_pkg::ANG_W-1:0]       scan_angle_i,
  input  ogc_pkg::clr_t                   fill_i,
  output logic signed [ogc_pkg::TRIG_W-1:0] sin_o,
  output logic signed [ogc_pkg::TRIG_W-1:0] cos_o
);
  import ogc_pkg::*;

  localparam logic [ANG_W-1:0] QT   = ANG_W'(QUARTER_TURN);
  localparam logic [ANG_W-1:0] FT   = ANG_W'(FULL_TURN);
  localparam int               DW   = ANG_W + 2;

  // Fold an angle onto the quarter wave: {negative, table address}
  function automatic logic [SIN_AW:0] fold(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0] r;
    logic             odd;
    logic             neg;
    if (a >= 3 * QT) begin
      r = a - 3 * QT; odd = 1'b1; neg = 1'b1;
    end else if (a >= 2 * QT) begin
      r = a - 2 * QT; odd = 1'b0; neg = 1'b1;
    end else if (a >= QT) begin
      r = a - QT;     odd = 1'b1; neg = 1'b0;
    end else begin
      r = a;          odd = 1'b0; neg = 1'b0;
    end
    return {neg, odd ? (SIN_AW'(QT) - SIN_AW'(r)) : SIN_AW'(r)};
  endfunction

  logic [ANG_W-1:0]        hd_red, sa_red;
  logic signed [DW-1:0]    diff;
  logic [ANG_W-1:0]        t_d, t_q;
  logic [ANG_W:0]          tc_sum;
  logic [ANG_W-1:0]        tc;
  logic [SIN_AW:0]         fs, fc;
  logic                    neg_s_q, neg_c_q;
  logic [SIN_W-1:0]        mag_s, mag_c;
  logic [SIN_W-1:0]        lut [SIN_DEPTH];
  logic [SIN_W-1:0]        fill_data;

  // Constant quarter-wave table, copied into both RAMs during the reset sweep
  for (genvar g = 0; g < SIN_DEPTH; g++) begin : g_lut
    assign lut[g] = quarter_sine(g);
  end
  assign fill_data = lut[fill_i.addr[SIN_AW-1:0]];

  // t = 450 deg + heading - angle, modulo a full turn
  always_comb begin
    hd_red = (heading_i >= FT) ? heading_i - FT : heading_i;
    sa_red = (scan_angle_i >= FT) ? scan_angle_i - FT : scan_angle_i;
    diff   = $signed({2'b00, hd_red}) - $signed({2'b00, sa_red}) + $signed(DW'(QUARTER_TURN));
    if (diff < 0) begin
      t_d = ANG_W'(diff + $signed(DW'(FULL_TURN)));
    end else if (diff >= $signed(DW'(FULL_TURN))) begin
      t_d = ANG_W'(diff - $signed(DW'(FULL_TURN)));
    end else begin
      t_d = ANG_W'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      t_q     <= t_d;
      neg_s_q <= fs[SIN_AW];
      neg_c_q <= fc[SIN_AW];
    end
  end

  // cos(t) = sin(t + 90 deg)
  always_comb begin
    tc_sum = {1'b0, t_q} + {1'b0, QT};
    tc     = (tc_sum >= {1'b0, FT}) ? ANG_W'(tc_sum - {1'b0, FT}) : ANG_W'(tc_sum);
    fs     = fold(t_q);
    fc     = fold(tc);
  end

  ogc_ram #(.WIDTH(SIN_W), .DEPTH(SIN_DEPTH)) u_sin_ram (
    .clk_i   (clk_i),
    .we_i    (fill_i.sine_we),
    .waddr_i (fill_i.addr[SIN_AW-1:0]),
    .wdata_i (fill_data),
    .re_i    (adv_i),
    .raddr_i (fs[SIN_AW-1:0]),
    .rdata_o (mag_s)
  );

  ogc_ram #(.WIDTH(SIN_W), .DEPTH(SIN_DEPTH)) u_cos_ram (
    .clk_i   (clk_i),
    .we_i    (fill_i.sine_we),
    .waddr_i (fill_i.addr[SIN_AW-1:0]),
    .wdata_i (fill_data),
    .re_i    (adv_i),
    .raddr_i (fc[SIN_AW-1:0]),
    .rdata_o (mag_c)
  );

  assign sin_o = neg_s_q ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  assign cos_o = neg_c_q ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

endmodule

// ===== src/ogc_proj.sv =====
// Projects a return into world coordinates and forms the grid cell request.
module ogc_proj (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              vld_i,
  input  ogc_pkg::item_t                    item_i,
  input  logic signed [ogc_pkg::TRIG_W-1:0] sin_i,
  input  logic signed [ogc_pkg::TRIG_W-1:0] cos_i,
  output ogc_pkg::cell_req_t                req_o
);
  import ogc_pkg::*;

  logic                     vld3_q, vld4_q;
  item_t                    item3_q, item4_q;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic signed [NW-1:0]     nx_d, ny_d, nx_q, ny_q;
  logic                     in_x, in_y;
  logic [GRID_BITS-1:0]     mx, my;

  // Products d*sin, d*cos
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item3_q <= item_i;
      px_q    <= $signed({1'b0, item_i.range_mm}) * sin_i;
      py_q    <= $signed({1'b0, item_i.range_mm}) * cos_i;
      item4_q <= item3_q;
      nx_q    <= nx_d;
      ny_q    <= ny_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (adv_i) begin
      vld3_q <= vld_i;
      vld4_q <= vld3_q;
    end
  end

  // Offset numerators: 4*x + grid and 2*y + grid, all Q15 mm
  always_comb begin
    nx_d = (NW'(item3_q.rx) <<< (Q15_SH + 2)) + (NW'(px_q) <<< 2) + GRID_Q_N;
    ny_d = (NW'(item3_q.ry) <<< (Q15_SH + 1)) + (NW'(py_q) <<< 1) + GRID_Q_N;
  end

  // Truncation toward zero: a small negative numerator still lands in cell 0
  always_comb begin
    in_x = (nx_q > X_LO) && (nx_q < X_HI);
    in_y = (ny_q > Y_LO) && (ny_q < Y_HI);
    mx   = nx_q[NW-1] ? '0 : nx_q[X_SH +: GRID_BITS];
    my   = ny_q[NW-1] ? '0 : ny_q[Y_SH +: GRID_BITS];

    req_o      = '0;
    req_o.vld  = vld4_q;
    if (item4_q.op == OP_READ) begin
      req_o.col  = item4_q.rcol;
      req_o.row  = item4_q.rrow;
      req_o.rd   = (32'(item4_q.rrow) < 32'(GRID_DIM)) && (32'(item4_q.rcol) < 32'(GRID_DIM));
      req_o.addr = {GRID_BITS'(item4_q.rrow), GRID_BITS'(item4_q.rcol)};
    end else if (item4_q.ok && in_x && in_y) begin
      req_o.wr   = 1'b1;
      req_o.col  = CELL_W'(mx);
      req_o.row  = CELL_W'(my);
      req_o.addr = {my, mx};
    end
  end

endmodule

// ===== src/ogc_grid.sv =====
// Hit counter store: read-modify-write with forwarding, plus the reset clear.
module ogc_grid (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  ogc_pkg::cell_req_t        req_i,
  input  ogc_pkg::clr_t             clr_i,
  input  logic [ogc_pkg::THR_W-1:0] thr_i,
  output logic                      res_vld_o,
  output ogc_pkg::result_t          res_o
);
  import ogc_pkg::*;

  cell_req_t             req5_q;
  logic                  vld5_q;
  logic [COUNT_BITS-1:0] rdata, cur, inc, cnt;
  logic                  lw_vld_q;
  logic [GRID_AW-1:0]    lw_addr_q;
  logic [COUNT_BITS-1:0] lw_data_q;
  logic                  upd;
  logic                  we;
  logic [GRID_AW-1:0]    waddr;
  logic [COUNT_BITS-1:0] wdata;

  ogc_ram #(.WIDTH(COUNT_BITS), .DEPTH(GRID_CELLS)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (adv_i),
    .raddr_i (req_i.addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      req5_q    <= req_i;
      lw_addr_q <= req5_q.addr;
      lw_data_q <= inc;
    end
  end

  // lw_* holds the write that went in on the same edge as this entry's read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q   <= 1'b0;
      lw_vld_q <= 1'b0;
    end else if (adv_i) begin
      vld5_q   <= req_i.vld;
      lw_vld_q <= upd;
    end
  end

  always_comb begin
    cur   = (lw_vld_q && (lw_addr_q == req5_q.addr)) ? lw_data_q : rdata;
    inc   = (cur == COUNT_MAX) ? cur : cur + 1'b1;
    upd   = vld5_q && req5_q.wr;
    we    = clr_i.grid_we || (adv_i && upd);
    waddr = clr_i.grid_we ? clr_i.addr[GRID_AW-1:0] : req5_q.addr;
    wdata = clr_i.grid_we ? '0 : inc;

    if (req5_q.wr) begin
      cnt = inc;
    end else if (req5_q.rd) begin
      cnt = cur;
    end else begin
      cnt = '0;
    end

    res_vld_o      = vld5_q;
    res_o.col      = req5_q.col;
    res_o.row      = req5_q.row;
    res_o.counted  = req5_q.wr;
    res_o.count    = (32'(cnt) > 32'(16'hFFFF)) ? 16'hFFFF : CNT_OUT_W'(cnt);
    res_o.occupied = (req5_q.wr || req5_q.rd) && (32'(cnt) > 32'(thr_i));
  end

endmodule

// ===== src/lidar_occupancy_grid_counter_core.sv =====
// Top level of the lidar occupancy grid hit counter.
//
// Each input item is either a lidar return to accumulate (opcode 0) or a read
// of one grid cell (opcode 1), and each gives exactly one result item, in
// order. A return is used only on even positions of a scan (scan_start forces
// even), when not rotating and when at least min_range_mm away; it is then
// projected through a quarter-wave sine table into a 64 x 64 grid of 128 mm
// tiles and that cell's 16-bit counter is incremented with saturation.
// Throughput is one item per clock while in_stall_o is low; the pipeline has
// six register stages, the last being the output register, and the grid RAM's
// read-modify-write is kept exact for back-to-back hits on the same cell by
// forwarding the last write. The whole pipeline holds only when the output
// register is full and stalled. After reset the block clears the grid RAM
// in one sweep over its cells (the sine table RAMs are loaded in the same
// sweep) with in_stall_o high; configuration writes are taken at any time
// but should only be issued while the block is idle.
module lidar_occupancy_grid_counter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic                                scan_start_i,
  input  logic [ogc_pkg::DIST_W-1:0]          distance_mm_i,
  input  logic [ogc_pkg::ANG_W-1:0]           scan_angle_i,
  input  logic signed [ogc_pkg::POS_W-1:0]    robot_x_mm_i,
  input  logic signed [ogc_pkg::POS_W-1:0]    robot_y_mm_i,
  input  logic [ogc_pkg::ANG_W-1:0]           heading_i,
  input  logic                                rotating_i,
  input  logic [ogc_pkg::CELL_W-1:0]          read_row_i,
  input  logic [ogc_pkg::CELL_W-1:0]          read_col_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ogc_pkg::CELL_W-1:0]          cell_col_o,
  output logic [ogc_pkg::CELL_W-1:0]          cell_row_o,
  output logic                                counted_o,
  output logic [ogc_pkg::CNT_OUT_W-1:0]       cell_count_o,
  output logic                                occupied_o,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ogc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ogc_pkg::CFG_DAT_W-1:0]       cfg_wdata_i
);
  import ogc_pkg::*;

  // Control state
  ogc_state_e          state_q, state_d;
  logic [CLR_W-1:0]    clr_cnt_q, clr_cnt_d;
  clr_t                clr;
  logic                odd_q, odd_d;
  logic [DIST_W-1:0]   min_range_q;
  logic [THR_W-1:0]    thr_q;

  // Pipeline
  logic                adv;        // every stage moves one step
  logic                accept;
  logic                used;
  item_t               item_d, item1_q, item2_q;
  logic                vld1_q, vld2_q;
  logic signed [TRIG_W-1:0] sin_v, cos_v;
  cell_req_t           req;
  logic                res_vld;
  result_t             res;
  logic                out_vld_q;
  result_t             out_q;

  // Reset sweep: clear the grid and load the sine table, then run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    clr.grid_we  = 1'b0;
    clr.sine_we  = 1'b0;
    clr.addr     = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr.grid_we = (32'(clr_cnt_q) < 32'(GRID_CELLS));
        clr.sine_we = (32'(clr_cnt_q) < 32'(SIN_DEPTH));
        clr_cnt_d   = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_W'(CLR_LEN - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= '0;
      thr_q       <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_RANGE: min_range_q <= cfg_wdata_i[DIST_W-1:0];
        CFG_OCC_THR:   thr_q       <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the pipeline holds only behind a full, stalled output register
  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_RUN) || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Scan parity: scan_start makes this return even; every return flips it
  always_comb begin
    used  = scan_start_i || !odd_q;
    odd_d = odd_q;
    if (accept && (opcode_i == OP_RETURN)) begin
      odd_d = used;
    end
    item_d.op       = opcode_i;
    item_d.ok       = (opcode_i == OP_RETURN) && used && !rotating_i &&
                      (distance_mm_i >= min_range_q);
    item_d.range_mm = distance_mm_i;
    item_d.rx       = robot_x_mm_i;
    item_d.ry       = robot_y_mm_i;
    item_d.rrow     = read_row_i;
    item_d.rcol     = read_col_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q  <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      odd_q <= odd_d;
      if (adv) begin
        vld1_q <= accept;
        vld2_q <= vld1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      item1_q <= item_d;
      item2_q <= item1_q;
    end
  end

  // Stages 1-2: angle fold and sine/cosine table read
  ogc_trig u_trig (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .heading_i    (heading_i),
    .scan_angle_i (scan_angle_i),
    .fill_i       (clr),
    .sin_o        (sin_v),
    .cos_o        (cos_v)
  );

  // Stages 3-4: world coordinates and cell selection
  ogc_proj u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (vld2_q),
    .item_i (item2_q),
    .sin_i  (sin_v),
    .cos_i  (cos_v),
    .req_o  (req)
  );

  // Stage 5: counter read-modify-write
  ogc_grid u_grid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .req_i     (req),
    .clr_i     (clr),
    .thr_i     (thr_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cell_col_o   = out_q.col;
  assign cell_row_o   = out_q.row;
  assign counted_o    = out_q.counted;
  assign cell_count_o = out_q.count;
  assign occupied_o   = out_q.occupied;

endmodule

// ===== src/ogc_check.sv =====
// Port-level assertions for the occupancy grid hit counter, bound to the top level.
module ogc_check (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_stall_o,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic [ogc_pkg::CELL_W-1:0]          cell_col_o,
  input  logic [ogc_pkg::CELL_W-1:0]          cell_row_o,
  input  logic                                counted_o,
  input  logic [ogc_pkg::CNT_OUT_W-1:0]       cell_count_o,
  input  logic                                occupied_o
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_col_o) &&
    $stable(cell_row_o) && $stable(counted_o) && $stable(cell_count_o) &&
    $stable(occupied_o))
    else $error("stalled result changed");

  // An increment never leaves a zero count
  a_counted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && counted_o |-> cell_count_o != '0)
    else $error("counted cell reports zero count");

  // Occupied means the count exceeds a threshold, so it is at least one
  a_occ_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && occupied_o |-> cell_count_o != '0)
    else $error("occupied cell reports zero count");

  // The grid clear keeps input closed right after reset
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open during grid clear");

endmodule

bind lidar_occupancy_grid_counter_core ogc_check u_check (.*);
